>>> hw/rtl/eeprom_register_controller_top_macros.svh
// Assertion macros for the EEPROM register controller.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef EEPROM_REGISTER_CONTROLLER_TOP_MACROS_SVH
`define EEPROM_REGISTER_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication
`define ERC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ERC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/erc_pkg.sv
// Shared types and constants of the EEPROM register controller.
// No dependencies.
`timescale 1ns / 1ps

package erc_pkg;

  localparam int unsigned DEPTH = 512;
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [7:0]  ERASED_BYTE     = 8'hFF;
  localparam logic [2:0]  MASK_RESET      = 3'd7;
  localparam logic [15:0] WRITE_TIME_RST  = 16'd2500;
  localparam logic [7:0]  ARM_TIME_RST    = 8'd4;

  localparam logic [2:0]  OP_READ   = 3'd1;
  localparam logic [2:0]  OP_WR     = 3'd2;
  localparam logic [2:0]  OP_ARM    = 3'd4;
  localparam logic [2:0]  OP_WR_ARM = 3'd6;

  localparam logic [1:0]  CFG_MASK  = 2'd0;
  localparam logic [1:0]  CFG_WTIME = 2'd1;
  localparam logic [1:0]  CFG_ATIME = 2'd2;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_CTRL    = 2'd0,
    REG_DATA    = 2'd1,
    REG_ADDR_LO = 2'd2,
    REG_ADDR_HI = 2'd3
  } reg_sel_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_BAD_OP = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef struct packed {
    action_t    action;
    reg_sel_t   reg_select;
    logic [7:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    status_t    status;
    logic       write_done;
  } out_item_t;

  typedef struct packed {
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
  } mem_req_t;

endpackage

>>> hw/rtl/erc_mem.sv
// EEPROM byte array with registered read and erase sweep after reset.
// Depends on erc_pkg.
`timescale 1ns / 1ps

module erc_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  erc_pkg::mem_req_t req,
  output logic [7:0]        rdata_r,
  output logic              clr_busy_r
);
  import erc_pkg::*;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_idx_r;
  logic [AW-1:0] clr_idx_nxt;
  logic          clr_busy_nxt;

  assign clr_idx_nxt  = clr_idx_r + 1'b1;
  assign clr_busy_nxt = clr_busy_r && (clr_idx_r != AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= ERASED_BYTE;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

endmodule

>>> hw/rtl/erc_ctrl.sv
// Register file, command decode and write/arm countdowns.
// Depends on erc_pkg; drives erc_mem through a mem_req_t.
`timescale 1ns / 1ps

module erc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_data,
  input  logic               acc,
  input  erc_pkg::in_item_t  item,
  input  logic [7:0]         mem_rdata,
  output erc_pkg::out_item_t result,
  output erc_pkg::mem_req_t  mem_req
);
  import erc_pkg::*;

  logic [2:0]  mask_r;
  logic [15:0] wtime_r;
  logic [7:0]  atime_r;

  logic [7:0]  data_r, data_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic        ld_pend_r, ld_pend_nxt;
  logic        wr_act_r, wr_act_nxt;
  logic [15:0] wcnt_r, wcnt_nxt;
  logic        arm_act_r, arm_act_nxt;
  logic [7:0]  acnt_r, acnt_nxt;

  logic [7:0]  data_eff;
  logic [15:0] addr;
  logic        in_rng;
  logic [2:0]  op;

  // data register forwarded from the memory while a load is in flight
  assign data_eff = ld_pend_r ? mem_rdata : data_r;
  assign addr     = {hi_r, lo_r};
  assign in_rng   = {1'b0, addr} < 17'(DEPTH);
  assign op       = item.write_value[2:0] & mask_r;

  always_comb begin
    data_nxt    = data_eff;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    ld_pend_nxt = 1'b0;
    wr_act_nxt  = wr_act_r;
    wcnt_nxt    = wcnt_r;
    arm_act_nxt = arm_act_r;
    acnt_nxt    = acnt_r;
    result      = '0;
    mem_req     = '0;
    if (acc) begin
      unique case (item.action)
        ACT_READ: begin
          unique case (item.reg_select)
            REG_CTRL:    result.read_value = {5'b0, arm_act_r, wr_act_r, 1'b0};
            REG_DATA:    result.read_value = data_eff;
            REG_ADDR_LO: result.read_value = lo_r;
            REG_ADDR_HI: result.read_value = hi_r;
            default:     result.read_value = '0;
          endcase
        end
        ACT_WRITE: begin
          if (wr_act_r) begin
            result.status = ST_BUSY;
          end else begin
            unique case (item.reg_select)
              REG_CTRL: begin
                case (op) inside
                  OP_READ: begin
                    if (!in_rng) begin
                      result.status = ST_RANGE;
                    end else begin
                      mem_req.rd_en   = 1'b1;
                      mem_req.rd_addr = addr[AW-1:0];
                      ld_pend_nxt     = 1'b1;
                    end
                  end
                  OP_WR, OP_WR_ARM: begin
                    if (!mask_r[2] || arm_act_r) begin
                      if (!in_rng) begin
                        result.status = ST_RANGE;
                      end else begin
                        wr_act_nxt = 1'b1;
                        wcnt_nxt   = wtime_r;
                      end
                    end
                  end
                  OP_ARM: begin
                    arm_act_nxt = 1'b1;
                    acnt_nxt    = atime_r;
                  end
                  default: result.status = ST_BAD_OP;
                endcase
              end
              REG_DATA:    data_nxt = item.write_value;
              REG_ADDR_LO: lo_nxt   = item.write_value;
              REG_ADDR_HI: hi_nxt   = item.write_value;
              default:     data_nxt = data_eff;
            endcase
          end
        end
        ACT_TICK: begin
          if (wr_act_r) begin
            if (wcnt_r != '0) begin
              wcnt_nxt = wcnt_r - 1'b1;
            end else begin
              mem_req.wr_en     = in_rng;
              mem_req.wr_addr   = addr[AW-1:0];
              mem_req.wr_data   = data_eff;
              wr_act_nxt        = 1'b0;
              result.write_done = 1'b1;
            end
          end
          if (arm_act_r) begin
            if (acnt_r != '0) begin
              acnt_nxt = acnt_r - 1'b1;
            end else begin
              arm_act_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= MASK_RESET;
      wtime_r   <= WRITE_TIME_RST;
      atime_r   <= ARM_TIME_RST;
      data_r    <= '0;
      lo_r      <= '0;
      hi_r      <= '0;
      ld_pend_r <= 1'b0;
      wr_act_r  <= 1'b0;
      wcnt_r    <= '0;
      arm_act_r <= 1'b0;
      acnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MASK:  mask_r  <= cfg_data[2:0];
          CFG_WTIME: wtime_r <= cfg_data;
          CFG_ATIME: atime_r <= cfg_data[7:0];
          default:   ;
        endcase
      end
      data_r    <= data_nxt;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      ld_pend_r <= ld_pend_nxt;
      wr_act_r  <= wr_act_nxt;
      wcnt_r    <= wcnt_nxt;
      arm_act_r <= arm_act_nxt;
      acnt_r    <= acnt_nxt;
    end
  end

endmodule

>>> hw/rtl/eeprom_register_controller_top.sv
// Top level of the EEPROM register controller: control, memory, result register.
// Depends on erc_pkg, erc_ctrl, erc_mem and the assertion macro header.
`timescale 1ns / 1ps

`include "eeprom_register_controller_top_macros.svh"

// Usage:
//  in_*   : one beat per register read, register write, clock tick or no-op.
//  out_*  : exactly one result beat per input beat, in order.
//  cfg_*  : write-only configuration (bit mask, write time, arm time);
//           write only while no beat is in flight.
//  Result: registered, and valid in the cycle after its input beat is taken.
//  Throughput: one beat per cycle while in_ready is high; the memory port gives
//  one read or one write per cycle, and a memory load is forwarded to the next beat.
//  Reset: synchronous, active low. Afterwards the memory is swept to 0xFF,
//  one byte per cycle across all 512 bytes, with in_ready low; cfg writes are
//  taken during the sweep.
//  Stall: the result register holds while out_ready is low, and in_ready
//  drops until it is freed.
module eeprom_register_controller_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  erc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output erc_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_data
);
  import erc_pkg::*;

  logic      acc;
  logic      clr_busy;
  logic [7:0] mem_rdata;
  mem_req_t  mem_req;
  out_item_t result;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  assign in_ready      = !clr_busy && (!out_valid_r || out_ready);
  assign acc           = in_valid && in_ready;
  assign out_valid_nxt = acc || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  erc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .item      (in_data),
    .mem_rdata (mem_rdata),
    .result    (result),
    .mem_req   (mem_req)
  );

  erc_mem u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (mem_req),
    .rdata_r    (mem_rdata),
    .clr_busy_r (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= result;
    end
  end

  `ERC_ASSERT_NOW(a_no_accept_in_sweep, clr_busy, !in_ready, "beat taken during erase sweep")
  `ERC_ASSERT_NOW(a_mem_wr_on_tick, mem_req.wr_en, acc && (in_data.action == ACT_TICK),
                  "memory write without a tick beat")
  `ERC_ASSERT_NEXT(a_commit_reported, mem_req.wr_en, out_valid && out_data.write_done,
                   "memory commit not reported as write_done")

endmodule

>>> test/eeprom_register_controller_top_tb.sv
// Self-checking testbench for eeprom_register_controller_top: register access, control ops,
// timed writes and master-enable expiry, checked beat by beat against an in-bench predictor.
// Depends on erc_pkg and the RTL of eeprom_register_controller_top.
`timescale 1ns / 1ps

module eeprom_register_controller_top_tb;
  import erc_pkg::*;

  localparam int TOTAL_BEATS    = 1300;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_addr  = '0;
  logic [15:0] cfg_data = '0;

  eeprom_register_controller_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [7:0]  ee_mem [DEPTH];
  logic [7:0]  ee_data, ee_addr_lo, ee_addr_hi, ee_ctrl;
  logic [15:0] ee_wcnt;
  logic        ee_wr_pend;
  logic [7:0]  ee_acnt;
  logic        ee_armed;
  logic [2:0]  mask_q;
  logic [15:0] wtime_q;
  logic [7:0]  atime_q;

  out_item_t pending_results [$];
  out_item_t want;
  int errors      = 0;
  int beats_sent  = 0;
  int checked     = 0;
  int commits     = 0;
  int settings    = 0;
  int idle_cycles = 0;
  bit tx_idle_en  = 1'b1;
  bit rx_idle_en  = 1'b1;
  bit hold_req    = 1'b0;

  task automatic eeprom_reset();
    for (int i = 0; i < DEPTH; i++) ee_mem[i] = ERASED_BYTE;
    ee_data    = '0;
    ee_addr_lo = '0;
    ee_addr_hi = '0;
    ee_ctrl    = '0;
    ee_wcnt    = '0;
    ee_wr_pend = 1'b0;
    ee_acnt    = '0;
    ee_armed   = 1'b0;
    mask_q     = MASK_RESET;
    wtime_q    = WRITE_TIME_RST;
    atime_q    = ARM_TIME_RST;
  endtask

  function automatic out_item_t eeprom_next(input in_item_t it);
    out_item_t  r;
    logic [15:0] a;
    logic [2:0] op;
    r  = '0;
    a  = {ee_addr_hi, ee_addr_lo};
    op = it.write_value[2:0] & mask_q;
    case (it.action)
      ACT_READ: begin
        case (it.reg_select)
          REG_CTRL:    r.read_value = ee_ctrl;
          REG_DATA:    r.read_value = ee_data;
          REG_ADDR_LO: r.read_value = ee_addr_lo;
          default:     r.read_value = ee_addr_hi;
        endcase
      end
      ACT_WRITE: begin
        if (ee_wr_pend) begin
          r.status = ST_BUSY;
        end else begin
          case (it.reg_select)
            REG_DATA:    ee_data = it.write_value;
            REG_ADDR_LO: ee_addr_lo = it.write_value;
            REG_ADDR_HI: ee_addr_hi = it.write_value;
            default: begin
              case (op)
                OP_READ: begin
                  if (a >= DEPTH) r.status = ST_RANGE;
                  else ee_data = ee_mem[a[AW-1:0]];
                end
                OP_WR, OP_WR_ARM: begin
                  if ((mask_q & OP_ARM) == '0 || (ee_ctrl[2:0] & mask_q & OP_ARM) != '0) begin
                    if (a >= DEPTH) begin
                      r.status = ST_RANGE;
                    end else begin
                      ee_ctrl    = ee_ctrl | {5'd0, OP_WR};
                      ee_wcnt    = wtime_q;
                      ee_wr_pend = 1'b1;
                    end
                  end
                end
                OP_ARM: begin
                  ee_ctrl  = ee_ctrl | {5'd0, OP_ARM};
                  ee_acnt  = atime_q;
                  ee_armed = 1'b1;
                end
                default: r.status = ST_BAD_OP;
              endcase
            end
          endcase
        end
      end
      ACT_TICK: begin
        if (ee_wr_pend) begin
          if (ee_wcnt != '0) begin
            ee_wcnt = ee_wcnt - 16'd1;
          end else begin
            if (a < DEPTH) ee_mem[a[AW-1:0]] = ee_data;
            ee_ctrl      = ee_ctrl & ~{5'd0, OP_WR};
            ee_wr_pend   = 1'b0;
            r.write_done = 1'b1;
            commits++;
          end
        end
        if (ee_armed) begin
          if (ee_acnt != '0) begin
            ee_acnt = ee_acnt - 8'd1;
          end else begin
            ee_ctrl  = ee_ctrl & ~{5'd0, OP_ARM};
            ee_armed = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t beat(input action_t a, input reg_sel_t s, input logic [7:0] v);
    in_item_t it;
    it.action      = a;
    it.reg_select  = s;
    it.write_value = v;
    return it;
  endfunction

  task automatic send_beat(input in_item_t it);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(eeprom_next(it));
    beats_sent++;
  endtask

  task automatic send_tick();
    send_beat(beat(ACT_TICK, reg_sel_t'($urandom_range(0, 3)), 8'($urandom)));
  endtask

  task automatic send_noise();
    send_beat(beat(action_t'($urandom_range(0, 3)), reg_sel_t'($urandom_range(0, 3)),
                   8'($urandom)));
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    wait_quiet();
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    case (idx)
      CFG_MASK:  mask_q  = val[2:0];
      CFG_WTIME: wtime_q = val;
      CFG_ATIME: atime_q = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [2:0] m, input logic [15:0] wt, input logic [7:0] at);
    cfg_write(CFG_MASK, {13'd0, m});
    cfg_write(CFG_WTIME, wt);
    cfg_write(CFG_ATIME, {8'd0, at});
    settings++;
  endtask

  // addr, data, optional arm, write start, ticks to commit, read back; or else a burst of noise beats
  task automatic run_sequence();
    logic [7:0] hi;
    if ($urandom_range(0, 9) < 7) begin
      hi = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(0, 1));
      send_beat(beat(ACT_WRITE, REG_ADDR_HI, hi));
      send_beat(beat(ACT_WRITE, REG_ADDR_LO, 8'($urandom)));
      send_beat(beat(ACT_WRITE, REG_DATA, 8'($urandom)));
      if ($urandom_range(0, 3) != 0)
        send_beat(beat(ACT_WRITE, REG_CTRL, {5'($urandom), OP_ARM}));
      repeat ($urandom_range(0, 2)) send_tick();
      send_beat(beat(ACT_WRITE, REG_CTRL,
                     {5'($urandom), ($urandom_range(0, 1) != 0) ? OP_WR : OP_WR_ARM}));
      while (ee_wr_pend) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_tick();
      end
      send_beat(beat(ACT_WRITE, REG_CTRL, {5'($urandom), OP_READ}));
      send_beat(beat(ACT_READ, REG_DATA, 8'($urandom)));
    end else begin
      repeat ($urandom_range(1, 6)) send_noise();
    end
  endtask

  // result checker
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (out_data.read_value !== want.read_value) begin
          $error("read_value: expected %0h, got %0h", want.read_value, out_data.read_value);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.write_done !== want.write_done) begin
          $error("write_done: expected %0d, got %0d", want.write_done, out_data.write_done);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("eeprom_register_controller_top_tb failed");
      $finish;
    end
  end

  task automatic test_register_access();
    send_beat(beat(ACT_READ, REG_CTRL, 8'h00));
    send_beat(beat(ACT_READ, REG_DATA, 8'hFF));
    send_beat(beat(ACT_WRITE, REG_ADDR_LO, 8'hFF));
    send_beat(beat(ACT_WRITE, REG_ADDR_HI, 8'hFF));
    send_beat(beat(ACT_READ, REG_ADDR_LO, 8'h00));
    send_beat(beat(ACT_READ, REG_ADDR_HI, 8'h00));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_READ}));
    send_beat(beat(ACT_NONE, REG_DATA, 8'hA5));
    send_beat(beat(ACT_TICK, REG_CTRL, 8'h00));
    send_beat(beat(ACT_WRITE, REG_ADDR_HI, 8'h02));
    send_beat(beat(ACT_WRITE, REG_ADDR_LO, 8'h00));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_ARM}));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_WR}));
  endtask

  task automatic test_control_ops();
    set_config(MASK_RESET, 16'd3, ARM_TIME_RST);
    send_beat(beat(ACT_WRITE, REG_ADDR_HI, 8'h00));
    send_beat(beat(ACT_WRITE, REG_CTRL, 8'h00));
    send_beat(beat(ACT_WRITE, REG_CTRL, 8'h03));
    send_beat(beat(ACT_WRITE, REG_CTRL, 8'h05));
    send_beat(beat(ACT_WRITE, REG_CTRL, 8'hFF));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'h1F, OP_WR}));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'h1F, OP_ARM}));
    send_beat(beat(ACT_WRITE, REG_DATA, 8'h00));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_WR_ARM}));
    send_beat(beat(ACT_READ, REG_CTRL, 8'h00));
    send_beat(beat(ACT_WRITE, REG_DATA, 8'h55));
    send_beat(beat(ACT_READ, REG_DATA, 8'h00));
    repeat (5) send_tick();
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_READ}));
    send_beat(beat(ACT_READ, REG_DATA, 8'h00));
    send_beat(beat(ACT_READ, REG_CTRL, 8'h00));
  endtask

  task automatic test_mask_sweep();
    for (int m = 0; m < 8; m++) begin
      set_config(3'(m), 16'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
      repeat (6) run_sequence();
    end
  endtask

  task automatic test_long_countdowns();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_config(MASK_RESET, 16'd300, 8'hFF);
    send_beat(beat(ACT_WRITE, REG_ADDR_HI, 8'h01));
    send_beat(beat(ACT_WRITE, REG_ADDR_LO, 8'hFF));
    send_beat(beat(ACT_WRITE, REG_DATA, 8'($urandom)));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_ARM}));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_WR}));
    while (ee_wr_pend) send_tick();
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_READ}));
    send_beat(beat(ACT_READ, REG_DATA, 8'h00));
    set_config(MASK_RESET, 16'd0, 8'd0);
    send_beat(beat(ACT_WRITE, REG_ADDR_HI, 8'h00));
    send_beat(beat(ACT_WRITE, REG_ADDR_LO, 8'h00));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_ARM}));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_WR_ARM}));
    send_beat(beat(ACT_READ, REG_CTRL, 8'h00));
    send_tick();
    send_beat(beat(ACT_READ, REG_CTRL, 8'h00));
    send_beat(beat(ACT_WRITE, REG_CTRL, {5'd0, OP_READ}));
    send_beat(beat(ACT_READ, REG_DATA, 8'h00));
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    set_config(MASK_RESET, 16'd2, 8'd3);
    hold_req = 1'b1;
    repeat (40) send_noise();
    repeat (4) run_sequence();
  endtask

  task automatic test_random_traffic();
    int phase_end;
    while (beats_sent < TOTAL_BEATS) begin
      if (beats_sent >= TOTAL_BEATS - 150) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      set_config(($urandom_range(0, 2) == 0) ? 3'($urandom) : MASK_RESET,
                 ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 20)),
                 ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom_range(0, 10)));
      phase_end = beats_sent + 100;
      while (beats_sent < phase_end) run_sequence();
    end
  endtask

  initial begin
    eeprom_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_control_ops();
    test_mask_sweep();
    test_long_countdowns();
    test_backpressure();
    test_random_traffic();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    wait_quiet();
    $display("%0d beats sent and %0d results checked over %0d configuration settings;",
             beats_sent, checked, settings);
    $display("%0d bytes committed to memory, with stalls and a long output hold.", commits);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("eeprom_register_controller_top_tb passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, pending_results.size());
      $display("eeprom_register_controller_top_tb failed");
    end
    $finish;
  end

endmodule
